### src/assert_macros.svh
// Assertion macros used by the texture palette decoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset
`define TPD_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Condition that must hold in the cycle after a trigger
`define TPD_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

### src/tpd_pkg.sv
// Shared types, constants and helper functions of the texture palette decoder
package tpd_pkg;

   // Fixed field widths
   localparam int DATA_W     = 8;
   localparam int CHAN_W     = 8;
   localparam int LEVEL_W    = 4;
   localparam int PIX_IDX_W  = 24;
   localparam int FMT_W      = 3;
   localparam int DIM_REG_W  = 13;
   localparam int LCNT_W     = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;
   localparam int COLOR_W    = 4 * CHAN_W;

   // Parameter defaults and fixed limits
   localparam int MAX_DIM_DEF     = 4096;
   localparam int PAL_ENTRIES_DEF = 256;
   localparam int MAX_LEVELS      = 13;
   localparam int MIP_MIN_DIM     = 8;
   localparam int PAL4_BYTES      = 64;
   localparam int BYTE_VALUES     = 256;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FORMAT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LEVELS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FLIP   = 3'd4;

   // Pixel formats
   localparam logic [FMT_W-1:0] FMT_PAL8  = 3'd0;
   localparam logic [FMT_W-1:0] FMT_PAL8A = 3'd1;
   localparam logic [FMT_W-1:0] FMT_PAL4  = 3'd2;
   localparam logic [FMT_W-1:0] FMT_RGB   = 3'd3;
   localparam logic [FMT_W-1:0] FMT_RGBA  = 3'd4;

   // Reset values of the registers
   localparam logic [FMT_W-1:0]     DEF_FORMAT = FMT_RGBA;
   localparam logic [DIM_REG_W-1:0] DEF_DIM    = 13'd256;
   localparam logic [LCNT_W-1:0]    DEF_LEVELS = 4'd1;

   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [1:0]        RGB_LAST    = 2'd2;
   localparam logic [1:0]        RGBA_LAST   = 2'd3;

   typedef struct packed {
      logic [FMT_W-1:0]  fmt;
      logic              flip;
      logic [LEVEL_W-1:0] levels;
   } cfg_type;

   // One decoded byte on its way to the pixel stage
   typedef struct packed {
      logic               valid;
      logic               pal;    // colors come from the palette read data
      logic               pair;   // two pixels from one byte
      logic [COLOR_W-1:0] color;  // chan0 in the low byte
   } item_type;

   function automatic int clamp_dim(int v, int max_dim);
      int r;
      r = v;
      if (r == 0) r = 1;
      else if (r > max_dim) r = max_dim;
      return r;
   endfunction

   function automatic int wrap_mod(int v, int m);
      int r;
      r = v;
      while (r >= m) r = r - m;
      return r;
   endfunction

   function automatic logic [LEVEL_W-1:0] levels_wanted(logic [LCNT_W-1:0] v);
      logic [LEVEL_W-1:0] r;
      r = LEVEL_W'(v);
      if (v == '0) r = LEVEL_W'(1);
      else if (int'(v) > MAX_LEVELS) r = LEVEL_W'(MAX_LEVELS);
      return r;
   endfunction

endpackage

### src/tpd_req_if.sv
// Byte input channel of the texture palette decoder
interface tpd_req_if;
   logic                         valid;
   logic                         ready;
   logic [tpd_pkg::DATA_W-1:0]   data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

### src/tpd_rsp_if.sv
// Pixel output channel of the texture palette decoder
interface tpd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tpd_pkg::LEVEL_W-1:0]    mip_level;
   logic [tpd_pkg::PIX_IDX_W-1:0]  pixel_index;
   logic [tpd_pkg::CHAN_W-1:0]     chan0;
   logic [tpd_pkg::CHAN_W-1:0]     chan1;
   logic [tpd_pkg::CHAN_W-1:0]     chan2;
   logic [tpd_pkg::CHAN_W-1:0]     chan3;
   logic                           last_of_run;
   logic                           image_done;

   modport source (output valid, output mip_level, output pixel_index, output chan0,
                   output chan1, output chan2, output chan3, output last_of_run,
                   output image_done, input ready);
   modport sink   (input valid, input mip_level, input pixel_index, input chan0,
                   input chan1, input chan2, input chan3, input last_of_run,
                   input image_done, output ready);
endinterface

### src/tpd_front.sv
// Byte front end: palette load, palette memory, RGB byte assembly
module tpd_front #(
   parameter int PALETTE_ENTRIES = tpd_pkg::PAL_ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  tpd_pkg::cfg_type              cfg,
   input  logic                          fire,
   input  logic [tpd_pkg::DATA_W-1:0]    data_byte,
   output tpd_pkg::item_type             item,
   output logic [tpd_pkg::COLOR_W-1:0]   rd0_ff,
   output logic [tpd_pkg::COLOR_W-1:0]   rd1_ff
);

   localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
   localparam int CNT_W  = $clog2(4 * PALETTE_ENTRIES);

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_PIX  = 3'b010,
      ST_HALT = 3'b100
   } state_type;

   state_type                        state_ff, state_in;
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;
   logic [1:0]                       bip_ff, bip_in;
   logic [3*tpd_pkg::CHAN_W-1:0]     part_ff;
   logic [tpd_pkg::COLOR_W-1:0]      pal_mem [PALETTE_ENTRIES];
   logic [PAL_AW-1:0]                wrap_lut [tpd_pkg::BYTE_VALUES];
   logic [PAL_AW-1:0]                idx0, idx1;
   logic [CNT_W-1:0]                 cnt_last;
   logic                             pal_wr;
   logic                             part_wr;

   // palette8 index wraps over the palette depth
   for (genvar i = 0; i < tpd_pkg::BYTE_VALUES; i++) begin : g_wrap
      assign wrap_lut[i] = PAL_AW'(tpd_pkg::wrap_mod(i, PALETTE_ENTRIES));
   end

   assign cnt_last = (cfg.fmt == tpd_pkg::FMT_PAL4) ? CNT_W'(tpd_pkg::PAL4_BYTES - 1)
                                                    : CNT_W'(4 * PALETTE_ENTRIES - 1);
   assign idx0 = (cfg.fmt == tpd_pkg::FMT_PAL4) ? PAL_AW'(data_byte[3:0])
                                                : wrap_lut[data_byte];
   assign idx1 = PAL_AW'(data_byte[7:4]);
   assign pal_wr = fire && (state_ff == ST_LOAD);

   always_comb begin
      item     = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      bip_in   = bip_ff;
      part_wr  = 1'b0;
      if (pal_wr) begin
         if (cnt_ff == cnt_last) begin
            cnt_in   = '0;
            state_in = ST_PIX;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end else if (fire && (state_ff == ST_PIX)) begin
         case (cfg.fmt)
            tpd_pkg::FMT_PAL8, tpd_pkg::FMT_PAL8A: begin
               item.valid = 1'b1;
               item.pal   = 1'b1;
            end
            tpd_pkg::FMT_PAL4: begin
               item.valid = 1'b1;
               item.pal   = 1'b1;
               item.pair  = 1'b1;
            end
            tpd_pkg::FMT_RGB: begin
               if (bip_ff == tpd_pkg::RGB_LAST) begin
                  item.valid = 1'b1;
                  item.color = {tpd_pkg::ALPHA_OPAQUE, data_byte, part_ff[15:0]};
                  bip_in     = '0;
               end else begin
                  part_wr = 1'b1;
                  bip_in  = bip_ff + 1'b1;
               end
            end
            tpd_pkg::FMT_RGBA: begin
               if (bip_ff == tpd_pkg::RGBA_LAST) begin
                  item.valid = 1'b1;
                  item.color = {data_byte, part_ff};
                  bip_in     = '0;
               end else begin
                  part_wr = 1'b1;
                  bip_in  = bip_ff + 1'b1;
               end
            end
            default: begin
               item = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_PIX;
         cnt_ff   <= '0;
         bip_ff   <= '0;
      end else if (restart) begin
         cnt_ff <= '0;
         bip_ff <= '0;
         if (cfg.fmt <= tpd_pkg::FMT_PAL4) begin
            state_ff <= ST_LOAD;
         end else if (cfg.fmt <= tpd_pkg::FMT_RGBA) begin
            state_ff <= ST_PIX;
         end else begin
            state_ff <= ST_HALT;
         end
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         bip_ff   <= bip_in;
      end
   end

   // partial pixel bytes, overwritten lane by lane
   always_ff @(posedge clock) begin
      if (part_wr) begin
         part_ff[{bip_ff, 3'b000} +: tpd_pkg::CHAN_W] <= data_byte;
      end
   end

   // palette memory: byte-lane writes during load, two reads per pixel byte
   always_ff @(posedge clock) begin
      if (pal_wr) begin
         pal_mem[cnt_ff[CNT_W-1:2]][{cnt_ff[1:0], 3'b000} +: tpd_pkg::CHAN_W] <= data_byte;
      end
      if (item.valid && item.pal) begin
         rd0_ff <= pal_mem[idx0];
         rd1_ff <= pal_mem[idx1];
      end
   end

endmodule

### src/tpd_pixel.sv
// Pixel stage: position and mip level tracking, result register
`include "assert_macros.svh"
module tpd_pixel #(
   parameter int MAX_DIM = tpd_pkg::MAX_DIM_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                restart,
   input  tpd_pkg::cfg_type                    cfg,
   input  logic [$clog2(MAX_DIM+1)-1:0]        base_w,
   input  logic [$clog2(MAX_DIM+1)-1:0]        base_h,
   input  tpd_pkg::item_type                   item,
   input  logic                                load,
   input  logic [tpd_pkg::COLOR_W-1:0]         rd0,
   input  logic [tpd_pkg::COLOR_W-1:0]         rd1,
   output logic                                work_free,
   tpd_rsp_if.source                           rsp
);

   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int AREA_W = 2 * DIM_W;

   tpd_pkg::item_type              work_ff;
   logic                           work_vld_ff;
   logic                           sub_ff;
   logic                           done_ff;
   logic [tpd_pkg::LEVEL_W-1:0]    level_ff;
   logic [DIM_W-1:0]               w_ff, h_ff, col_ff, y_ff;
   logic [AREA_W-1:0]              pos_ff, area_ff;

   logic                           rsp_vld_ff;
   logic [tpd_pkg::LEVEL_W-1:0]    rsp_level_ff;
   logic [tpd_pkg::PIX_IDX_W-1:0]  rsp_index_ff;
   logic [tpd_pkg::COLOR_W-1:0]    rsp_color_ff;
   logic                           rsp_last_ff;
   logic                           rsp_done_ff;

   logic                           flip_act;
   logic                           halted;
   logic                           out_free;
   logic                           drop;
   logic                           step;
   logic [DIM_W-1:0]               col_nx;
   logic                           row_wrap;
   logic [AREA_W-1:0]              pos_nx;
   logic [AREA_W-1:0]              limit;
   logic [tpd_pkg::LEVEL_W:0]      lvl_nx;
   logic                           level_end;
   logic                           next_level;
   logic                           image_end;
   logic                           last_px;
   logic [AREA_W-1:0]              idx_full;
   logic [tpd_pkg::COLOR_W-1:0]    entry;
   logic [tpd_pkg::COLOR_W-1:0]    color;
   logic [DIM_W-1:0]               half_h;

   assign flip_act = (cfg.fmt == tpd_pkg::FMT_PAL4) && cfg.flip;
   // a 1x1 palette4 level holds no pixel
   assign halted   = done_ff || ((cfg.fmt == tpd_pkg::FMT_PAL4) &&
                                 (w_ff == DIM_W'(1)) && (h_ff == DIM_W'(1)));
   assign out_free = !rsp_vld_ff || rsp.ready;
   assign drop     = work_vld_ff && halted;
   assign step     = work_vld_ff && !halted && out_free;

   always_comb begin
      col_nx     = col_ff + 1'b1;
      row_wrap   = (col_nx == w_ff);
      pos_nx     = pos_ff + 1'b1;
      limit      = (cfg.fmt == tpd_pkg::FMT_PAL4) ? {area_ff[AREA_W-1:1], 1'b0} : area_ff;
      level_end  = (pos_nx >= limit);
      lvl_nx     = {1'b0, level_ff} + 1'b1;
      next_level = level_end && (lvl_nx < {1'b0, cfg.levels}) &&
                   (w_ff > DIM_W'(tpd_pkg::MIP_MIN_DIM)) &&
                   (h_ff > DIM_W'(tpd_pkg::MIP_MIN_DIM));
      image_end  = level_end && !next_level;
      last_px    = image_end || !work_ff.pair || sub_ff;
      idx_full   = (y_ff * w_ff) + AREA_W'(col_ff);
      entry      = sub_ff ? rd1 : rd0;
      // palette entries swap bytes 0 and 2
      color      = work_ff.pal ? {entry[31:24], entry[7:0], entry[15:8], entry[23:16]}
                               : work_ff.color;
      half_h     = h_ff >> 1;
   end

   assign work_free = !work_vld_ff || drop || (step && last_px);

   always_ff @(posedge clock) begin
      area_ff <= w_ff * h_ff;
      if (load) begin
         work_ff <= item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_vld_ff <= 1'b0;
         sub_ff      <= 1'b0;
         done_ff     <= 1'b0;
         level_ff    <= '0;
         w_ff        <= DIM_W'(tpd_pkg::clamp_dim(int'(tpd_pkg::DEF_DIM), MAX_DIM));
         h_ff        <= DIM_W'(tpd_pkg::clamp_dim(int'(tpd_pkg::DEF_DIM), MAX_DIM));
         col_ff      <= '0;
         y_ff        <= '0;
         pos_ff      <= '0;
      end else if (restart) begin
         work_vld_ff <= 1'b0;
         sub_ff      <= 1'b0;
         done_ff     <= 1'b0;
         level_ff    <= '0;
         w_ff        <= base_w;
         h_ff        <= base_h;
         col_ff      <= '0;
         y_ff        <= flip_act ? (base_h - 1'b1) : '0;
         pos_ff      <= '0;
      end else begin
         work_vld_ff <= work_free ? load : 1'b1;
         if (load) begin
            sub_ff <= 1'b0;
         end else if (step && !last_px) begin
            sub_ff <= 1'b1;
         end
         if (step) begin
            if (next_level) begin
               level_ff <= lvl_nx[tpd_pkg::LEVEL_W-1:0];
               w_ff     <= w_ff >> 1;
               h_ff     <= half_h;
               col_ff   <= '0;
               y_ff     <= flip_act ? (half_h - 1'b1) : '0;
               pos_ff   <= '0;
            end else if (image_end) begin
               done_ff <= 1'b1;
            end else begin
               pos_ff <= pos_nx;
               if (row_wrap) begin
                  col_ff <= '0;
                  y_ff   <= flip_act ? (y_ff - 1'b1) : (y_ff + 1'b1);
               end else begin
                  col_ff <= col_nx;
               end
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (step) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_level_ff <= level_ff;
         rsp_index_ff <= tpd_pkg::PIX_IDX_W'(idx_full);
         rsp_color_ff <= color;
         rsp_last_ff  <= last_px;
         rsp_done_ff  <= image_end;
      end
   end

   assign rsp.valid       = rsp_vld_ff;
   assign rsp.mip_level   = rsp_level_ff;
   assign rsp.pixel_index = rsp_index_ff;
   assign rsp.chan0       = rsp_color_ff[7:0];
   assign rsp.chan1       = rsp_color_ff[15:8];
   assign rsp.chan2       = rsp_color_ff[23:16];
   assign rsp.chan3       = rsp_color_ff[31:24];
   assign rsp.last_of_run = rsp_last_ff;
   assign rsp.image_done  = rsp_done_ff;

   `TPD_ASSERT(a_col_in_row, !work_vld_ff || (col_ff < w_ff), "column beyond level width")
   `TPD_ASSERT_NEXT(a_done_after_end, step && image_end && !restart, done_ff, "image end not latched")
   `TPD_ASSERT_NEXT(a_restart_clears, restart, !done_ff && (level_ff == '0) && (pos_ff == '0), "restart left state")
   `TPD_ASSERT(a_done_closes_run, !(rsp_vld_ff && rsp_done_ff) || rsp_last_ff, "image done without last beat")

endmodule

### src/texture_palette_decoder_core.sv
// Top level of the texture palette decoder: config registers, front end, pixel stage
//
//   channel   | dir | payload                                         | handshake
//   req_chan  | in  | data_byte                                       | valid/ready
//   rsp_chan  | out | mip_level pixel_index chan0..chan3 last/done     | valid/ready
//   csr_*     | in  | csr_index csr_wdata                             | csr_wen
//
// Palette8, rgb888 and rgba8888 take one byte per cycle while rsp is ready; palette4
// holds each byte until the single result register, one beat per cycle while rsp is
// ready, has sent both its pixels. A beat passes work_ff, then the result register.
// Palette load takes 64 (palette4) or 4*PALETTE_ENTRIES bytes, one per cycle.
// A config write restarts decoding; req ready is low for the cycle after it.
// Reset is synchronous; a stalled rsp beat holds the pixel stage, which holds req.
module texture_palette_decoder_core #(
   parameter int MAX_DIM         = tpd_pkg::MAX_DIM_DEF,
   parameter int PALETTE_ENTRIES = tpd_pkg::PAL_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [tpd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tpd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   tpd_req_if.sink                           req_chan,
   tpd_rsp_if.source                         rsp_chan
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);

   logic [tpd_pkg::FMT_W-1:0]       fmt_ff;
   logic [tpd_pkg::DIM_REG_W-1:0]   bw_ff, bh_ff;
   logic [tpd_pkg::LCNT_W-1:0]      lcnt_ff;
   logic                            flip_ff;
   logic                            restart_ff;

   tpd_pkg::cfg_type                cfg;
   logic [DIM_W-1:0]                base_w, base_h;
   tpd_pkg::item_type               item;
   logic [tpd_pkg::COLOR_W-1:0]     rd0, rd1;
   logic                            work_free;
   logic                            fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff     <= tpd_pkg::DEF_FORMAT;
         bw_ff      <= tpd_pkg::DEF_DIM;
         bh_ff      <= tpd_pkg::DEF_DIM;
         lcnt_ff    <= tpd_pkg::DEF_LEVELS;
         flip_ff    <= 1'b0;
         restart_ff <= 1'b0;
      end else begin
         restart_ff <= 1'b0;
         if (csr_wen) begin
            case (csr_index)
               tpd_pkg::REG_FORMAT: begin
                  fmt_ff     <= csr_wdata[tpd_pkg::FMT_W-1:0];
                  restart_ff <= 1'b1;
               end
               tpd_pkg::REG_WIDTH: begin
                  bw_ff      <= csr_wdata[tpd_pkg::DIM_REG_W-1:0];
                  restart_ff <= 1'b1;
               end
               tpd_pkg::REG_HEIGHT: begin
                  bh_ff      <= csr_wdata[tpd_pkg::DIM_REG_W-1:0];
                  restart_ff <= 1'b1;
               end
               tpd_pkg::REG_LEVELS: begin
                  lcnt_ff    <= csr_wdata[tpd_pkg::LCNT_W-1:0];
                  restart_ff <= 1'b1;
               end
               tpd_pkg::REG_FLIP: begin
                  flip_ff    <= csr_wdata[0];
                  restart_ff <= 1'b1;
               end
               default: begin
                  restart_ff <= 1'b0;
               end
            endcase
         end
      end
   end

   assign cfg.fmt    = fmt_ff;
   assign cfg.flip   = flip_ff;
   assign cfg.levels = tpd_pkg::levels_wanted(lcnt_ff);
   assign base_w     = DIM_W'(tpd_pkg::clamp_dim(int'(bw_ff), MAX_DIM));
   assign base_h     = DIM_W'(tpd_pkg::clamp_dim(int'(bh_ff), MAX_DIM));

   assign req_chan.ready = work_free && !restart_ff;
   assign fire           = req_chan.valid && req_chan.ready;

   tpd_front #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart_ff),
      .cfg       (cfg),
      .fire      (fire),
      .data_byte (req_chan.data_byte),
      .item      (item),
      .rd0_ff    (rd0),
      .rd1_ff    (rd1)
   );

   tpd_pixel #(
      .MAX_DIM (MAX_DIM)
   ) u_pixel (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart_ff),
      .cfg       (cfg),
      .base_w    (base_w),
      .base_h    (base_h),
      .item      (item),
      .load      (item.valid),
      .rd0       (rd0),
      .rd1       (rd1),
      .work_free (work_free),
      .rsp       (rsp_chan)
   );

endmodule

### dv/tpd_pixel_checker.sv
// Scoreboard of the texture palette decoder: predicts pixel beats from accepted bytes and compares
`timescale 1ns / 100ps
module tpd_pixel_checker
   import tpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  run_over,
   tpd_req_if                    req_mon,
   tpd_rsp_if                    rsp_mon,
   output int                    pixels_owed,
   output logic                  image_complete,
   output int                    error_count
);

   localparam int MAX_DIM     = MAX_DIM_DEF;
   localparam int PAL_ENTRIES = PAL_ENTRIES_DEF;
   localparam int PRINT_CAP   = 40;

   typedef enum logic [1:0] {LOAD_PALETTE, DECODE_PIXELS, IMAGE_DONE} decode_state_e;

   typedef struct packed {
      logic [LEVEL_W-1:0]   level;
      logic [PIX_IDX_W-1:0] index;
      logic [CHAN_W-1:0]    c0;
      logic [CHAN_W-1:0]    c1;
      logic [CHAN_W-1:0]    c2;
      logic [CHAN_W-1:0]    c3;
      logic                 last;
      logic                 done;
   } pixel_t;

   // register copies
   logic [FMT_W-1:0]     fmt;
   logic [DIM_REG_W-1:0] width_reg;
   logic [DIM_REG_W-1:0] height_reg;
   logic [LCNT_W-1:0]    levels_reg;
   logic                 flip_reg;

   // decoder state
   logic [COLOR_W-1:0] palette_mem [PAL_ENTRIES];
   decode_state_e      state;
   int                 pal_count;
   int                 byte_pos;
   logic [23:0]        partial;
   int                 col;
   int                 row;
   int                 level;
   int                 lw;
   int                 lh;

   pixel_t due_pixels[$];
   int     errors;
   int     beat_no;
   bit     tail_checked;

   assign error_count = errors;

   function automatic int fit_dim(logic [DIM_REG_W-1:0] v);
      if (v == '0) return 1;
      if (int'(v) > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   function automatic int level_goal();
      if (levels_reg == '0) return 1;
      if (int'(levels_reg) > MAX_LEVELS) return MAX_LEVELS;
      return int'(levels_reg);
   endfunction

   // palette4 drops the odd trailing pixel of a level
   function automatic int pixels_in_level();
      int n;
      n = lw * lh;
      if (fmt == FMT_PAL4) n = n & ~1;
      return n;
   endfunction

   function automatic void restart_decode();
      pal_count = 0;
      byte_pos  = 0;
      partial   = '0;
      col       = 0;
      row       = 0;
      level     = 0;
      lw        = fit_dim(width_reg);
      lh        = fit_dim(height_reg);
      if (fmt <= FMT_PAL4) state = LOAD_PALETTE;
      else if (fmt <= FMT_RGBA) state = DECODE_PIXELS;
      else state = IMAGE_DONE;
      if (state == DECODE_PIXELS && pixels_in_level() == 0) state = IMAGE_DONE;
   endfunction

   function automatic void reset_model();
      fmt        = DEF_FORMAT;
      width_reg  = DEF_DIM;
      height_reg = DEF_DIM;
      levels_reg = DEF_LEVELS;
      flip_reg   = 1'b0;
      for (int i = 0; i < PAL_ENTRIES; i++) palette_mem[i] = '0;
      due_pixels.delete();
      restart_decode();
   endfunction

   function automatic void apply_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_FORMAT: fmt        = value[FMT_W-1:0];
         REG_WIDTH:  width_reg  = value[DIM_REG_W-1:0];
         REG_HEIGHT: height_reg = value[DIM_REG_W-1:0];
         REG_LEVELS: levels_reg = value[LCNT_W-1:0];
         REG_FLIP:   flip_reg   = value[0];
         default:    return;
      endcase
      restart_decode();
   endfunction

   // queues one pixel and advances position; returns 1 when it ends the image
   function automatic bit push_pixel(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                                     logic [7:0] c3);
      pixel_t p;
      int     y;
      y = (fmt == FMT_PAL4 && flip_reg) ? lh - 1 - row : row;
      p.level = LEVEL_W'(level);
      p.index = PIX_IDX_W'(y * lw + col);
      p.c0    = c0;
      p.c1    = c1;
      p.c2    = c2;
      p.c3    = c3;
      p.last  = 1'b0;
      p.done  = 1'b0;
      col++;
      if (col >= lw) begin
         col = 0;
         row++;
      end
      if (row * lw + col >= pixels_in_level()) begin
         if (level + 1 < level_goal() && lw > MIP_MIN_DIM && lh > MIP_MIN_DIM) begin
            level++;
            lw  = lw >> 1;
            lh  = lh >> 1;
            col = 0;
            row = 0;
         end else begin
            state  = IMAGE_DONE;
            p.done = 1'b1;
            due_pixels.push_back(p);
            return 1'b1;
         end
      end
      due_pixels.push_back(p);
      return 1'b0;
   endfunction

   // stored colors come out with bytes 0 and 2 swapped
   function automatic bit push_palette_pixel(int idx);
      logic [COLOR_W-1:0] e;
      e = palette_mem[idx % PAL_ENTRIES];
      return push_pixel(e[23:16], e[15:8], e[7:0], e[31:24]);
   endfunction

   function automatic void decode_byte(logic [DATA_W-1:0] b);
      int     queued;
      int     total;
      int     ent;
      pixel_t p;
      queued = due_pixels.size();
      if (state == IMAGE_DONE) return;
      if (state == LOAD_PALETTE) begin
         total = (fmt == FMT_PAL4) ? PAL4_BYTES : PAL_ENTRIES * 4;
         ent   = (pal_count >> 2) % PAL_ENTRIES;
         palette_mem[ent][(pal_count % 4) * 8 +: 8] = b;
         pal_count++;
         if (pal_count >= total) begin
            pal_count = 0;
            state     = (pixels_in_level() == 0) ? IMAGE_DONE : DECODE_PIXELS;
         end
         return;
      end
      if (fmt == FMT_PAL8 || fmt == FMT_PAL8A) begin
         void'(push_palette_pixel(int'(b)));
      end else if (fmt == FMT_PAL4) begin
         // low nibble first; the high one is dropped if the low one ended the image
         if (!push_palette_pixel(int'(b[3:0]))) void'(push_palette_pixel(int'(b[7:4])));
      end else if (fmt == FMT_RGB) begin
         partial[byte_pos * 8 +: 8] = b;
         byte_pos++;
         if (byte_pos >= 3) begin
            void'(push_pixel(partial[7:0], partial[15:8], partial[23:16], ALPHA_OPAQUE));
            byte_pos = 0;
            partial  = '0;
         end
      end else begin
         if (byte_pos >= 3) begin
            void'(push_pixel(partial[7:0], partial[15:8], partial[23:16], b));
            byte_pos = 0;
            partial  = '0;
         end else begin
            partial[byte_pos * 8 +: 8] = b;
            byte_pos++;
         end
      end
      if (due_pixels.size() > queued) begin
         p      = due_pixels.pop_back();
         p.last = 1'b1;
         due_pixels.push_back(p);
      end
   endfunction

   task automatic report_mismatch(string msg);
      // past the cap mismatches are only counted
      if (errors < PRINT_CAP) $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
   endtask

   task automatic compare_field(string name, logic [PIX_IDX_W-1:0] got,
                                logic [PIX_IDX_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("beat %0d %s: got 0x%0h, want 0x%0h",
                                   beat_no, name, got, want));
   endtask

   task automatic check_beat();
      pixel_t want;
      if (due_pixels.size() == 0) begin
         report_mismatch($sformatf("pixel beat level %0d index %0d with nothing expected",
                                   rsp_mon.mip_level, rsp_mon.pixel_index));
         return;
      end
      want = due_pixels.pop_front();
      beat_no++;
      compare_field("mip_level", PIX_IDX_W'(rsp_mon.mip_level), PIX_IDX_W'(want.level));
      compare_field("pixel_index", rsp_mon.pixel_index, want.index);
      compare_field("chan0", PIX_IDX_W'(rsp_mon.chan0), PIX_IDX_W'(want.c0));
      compare_field("chan1", PIX_IDX_W'(rsp_mon.chan1), PIX_IDX_W'(want.c1));
      compare_field("chan2", PIX_IDX_W'(rsp_mon.chan2), PIX_IDX_W'(want.c2));
      compare_field("chan3", PIX_IDX_W'(rsp_mon.chan3), PIX_IDX_W'(want.c3));
      compare_field("last_of_run", PIX_IDX_W'(rsp_mon.last_of_run), PIX_IDX_W'(want.last));
      compare_field("image_done", PIX_IDX_W'(rsp_mon.image_done), PIX_IDX_W'(want.done));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reset_model();
      end else begin
         if (csr_wen) apply_write(csr_index, csr_wdata);
         if (req_mon.valid && req_mon.ready) decode_byte(req_mon.data_byte);
         if (rsp_mon.valid && rsp_mon.ready) check_beat();
         if (run_over && !tail_checked) begin
            tail_checked = 1'b1;
            while (due_pixels.size() != 0) begin
               report_mismatch($sformatf("pixel level %0d index %0d never arrived",
                                         due_pixels[0].level, due_pixels[0].index));
               void'(due_pixels.pop_front());
            end
         end
      end
      pixels_owed    <= due_pixels.size();
      image_complete <= (state == IMAGE_DONE);
   end

endmodule

### dv/tb_texture_palette_decoder_core.sv
// Testbench top of the texture palette decoder: clock, reset, byte stimulus and verdict
`timescale 1ns / 100ps
module tb_texture_palette_decoder_core;
   import tpd_pkg::*;

   localparam int CLOCK_PERIOD       = 8;
   localparam int RESET_CYCLES       = 12;
   localparam int IDLE_PCT           = 11;
   localparam int SETTLE_CYCLES      = 6;
   localparam int HOLD_CYCLES        = 300;
   localparam int DRAIN_LIMIT        = 5000;
   localparam int RANDOM_PIXEL_BYTES = 750;
   localparam int MAX_PAL8_LOADS     = 2;
   localparam int FULL_FEED          = 450;
   localparam int TIMEOUT_NS         = 4_000_000;
   localparam int DIM_REG_MAX        = (1 << DIM_REG_W) - 1;

   // format codes with no decoder behind them
   localparam logic [FMT_W-1:0] FMT_SPARE_LO = 3'd5;
   localparam logic [FMT_W-1:0] FMT_SPARE_HI = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wen;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  run_over;
   int                    pixels_owed;
   logic                  image_complete;
   int                    error_count;

   bit calm;
   int hold_requests;
   int hold_served;
   int pixel_bytes;

   tpd_req_if req_chan();
   tpd_rsp_if rsp_chan();

   texture_palette_decoder_core dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   tpd_pixel_checker pixel_sb (
      .clock          (clock),
      .reset          (reset),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .run_over       (run_over),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .pixels_owed    (pixels_owed),
      .image_complete (image_complete),
      .error_count    (error_count)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   initial begin
      #(TIMEOUT_NS);
      $display("DONE: errors detected");
      $finish;
   end

   // pixel receiver: random stalls, plus long hold-offs on request
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_served++;
         end else begin
            rsp_chan.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   task automatic send_byte(input logic [DATA_W-1:0] value);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic hold_until_drained(input bit settle);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pixels_owed != 0) @(posedge clock);
      // bytes that make no pixel may still be in flight
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
   endtask

   task automatic configure(input logic [FMT_W-1:0] fmt, input int w, input int h,
                            input int levels, input bit flip);
      hold_until_drained(1'b1);
      write_reg(REG_FORMAT, int'(fmt));
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_LEVELS, levels);
      write_reg(REG_FLIP, int'(flip));
      csr_wen <= 1'b0;
   endtask

   task automatic load_palette(input logic [FMT_W-1:0] fmt, input bit broken);
      int n;
      n = (fmt == FMT_PAL4) ? PAL4_BYTES : PAL_ENTRIES_DEF * 4;
      if (broken) n = $urandom_range(n - 1, 1);
      repeat (n) send_byte(DATA_W'($urandom_range(255)));
   endtask

   // random bytes until the image is predicted complete or the cap is hit, then extra bytes
   task automatic feed_pixels(input int cap, input int extra);
      int sent;
      sent = 0;
      while (!image_complete && sent < cap) begin
         if ($urandom_range(59) == 0) hold_until_drained(1'b0);
         send_byte(DATA_W'($urandom_range(255)));
         sent++;
      end
      pixel_bytes += sent;
      repeat (extra) send_byte(DATA_W'($urandom_range(255)));
   endtask

   function automatic int pick_dim(int top);
      int r;
      r = $urandom_range(99);
      if (r < 4) return 0;
      if (r < 8) return $urandom_range(DIM_REG_MAX, MAX_DIM_DEF);
      return $urandom_range(top, 1);
   endfunction

   initial begin
      int               phase;
      int               r;
      int               w;
      int               h;
      int               levels;
      int               pal8_loads;
      int               guard;
      bit               flip;
      bit               broken;
      logic [FMT_W-1:0] fmt;

      reset              <= 1'b1;
      csr_wen            <= 1'b0;
      csr_index          <= REG_FORMAT;
      csr_wdata          <= '0;
      run_over           <= 1'b0;
      req_chan.valid     <= 1'b0;
      req_chan.data_byte <= '0;
      pal8_loads = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: rgba8888 256x256, byte extremes
      for (int i = 0; i < 8; i++) send_byte((i % 2 == 0) ? 8'h00 : 8'hFF);
      // rgb888, zero width and zero level count, then bytes past the end
      configure(FMT_RGB, 0, 2, 0, 1'b0);
      feed_pixels(10, 2);
      // spare formats swallow every byte
      configure(FMT_SPARE_LO, 5, 5, 1, 1'b0);
      repeat (2) send_byte(DATA_W'($urandom_range(255)));
      configure(FMT_SPARE_HI, DIM_REG_MAX, DIM_REG_MAX, 15, 1'b1);
      repeat (2) send_byte(DATA_W'($urandom_range(255)));
      // palette4 1x1 holds no pixel: the image ends with the palette
      configure(FMT_PAL4, 1, 1, 1, 1'b1);
      load_palette(FMT_PAL4, 1'b0);
      repeat (2) send_byte(DATA_W'($urandom_range(255)));
      // palette4 3x1: odd count drops the last pixel
      configure(FMT_PAL4, 3, 1, 1, 1'b1);
      load_palette(FMT_PAL4, 1'b0);
      feed_pixels(4, 1);
      // palette4 9x9 flipped, odd level then a 4x4 level
      configure(FMT_PAL4, 9, 9, 13, 1'b1);
      load_palette(FMT_PAL4, 1'b0);
      feed_pixels(60, 1);
      // oversized and flipped: indices near the top of the range
      configure(FMT_PAL4, DIM_REG_MAX, MAX_DIM_DEF + 1, 15, 1'b1);
      load_palette(FMT_PAL4, 1'b0);
      feed_pixels(3, 0);
      // palette8 at the width limit
      configure(FMT_PAL8, MAX_DIM_DEF, 1, 1, 1'b0);
      load_palette(FMT_PAL8, 1'b0);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h7F);
      configure(FMT_PAL8A, 1, 3, 2, 1'b0);
      load_palette(FMT_PAL8A, 1'b0);
      feed_pixels(5, 1);

      pixel_bytes = 0;
      phase = 0;
      while (pixel_bytes < RANDOM_PIXEL_BYTES) begin
         r = $urandom_range(99);
         if (r < 8 && pal8_loads < MAX_PAL8_LOADS) begin
            fmt = r[0] ? FMT_PAL8A : FMT_PAL8;
            pal8_loads++;
         end else if (r < 45) begin
            fmt = FMT_PAL4;
         end else if (r < 65) begin
            fmt = FMT_RGB;
         end else if (r < 93) begin
            fmt = FMT_RGBA;
         end else begin
            fmt = FMT_W'(FMT_SPARE_LO + $urandom_range(FMT_SPARE_HI - FMT_SPARE_LO));
         end
         w      = pick_dim((fmt == FMT_PAL4) ? 20 : 10);
         h      = pick_dim((fmt == FMT_PAL4) ? 20 : 10);
         levels = $urandom_range(15);
         flip   = $urandom_range(1);
         // phase 1: receiver hold-off on a full palette4 image; phase 2: no idling
         if (phase == 1) begin
            fmt    = FMT_PAL4;
            w      = 16;
            h      = 16;
            levels = 1;
         end else if (phase == 2) begin
            fmt    = FMT_RGB;
            w      = 8;
            h      = 8;
            levels = 1;
         end
         configure(fmt, w, h, levels, flip);
         calm   = (phase == 2);
         broken = 1'b0;
         if (fmt <= FMT_PAL4) begin
            broken = (phase != 1) && ($urandom_range(9) == 0);
            load_palette(fmt, broken);
         end
         if (phase == 1) hold_requests++;
         if (!broken)
            feed_pixels(($urandom_range(9) < 2) ? $urandom_range(30, 1) : FULL_FEED,
                        $urandom_range(3));
         calm = 1'b0;
         phase++;
      end

      req_chan.valid <= 1'b0;
      guard = 0;
      @(posedge clock);
      while (pixels_owed != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      run_over <= 1'b1;
      repeat (2) @(posedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
